### hdl/assert_macros.svh
// Assertion macros shared by the RTL of the multiplexer frame deframer.
// No dependencies; compiles to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising edge outside reset
`define ASSERT_PROP(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
// Check that a condition implies a consequence in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### hdl/cmuxdf_pkg.sv
// Package for the multiplexer frame deframer: codes, phase type, CRC step.
// No dependencies.
package cmuxdf_pkg;

   // Framing constants
   localparam logic [7:0] FLAG_BYTE     = 8'hF9;
   localparam logic [7:0] PF_CLEAR_MASK = 8'hEF;
   localparam logic [7:0] FCS_GOOD      = 8'hCF;
   localparam logic [7:0] CRC_INIT      = 8'hFF;
   localparam logic [7:0] CRC_POLY_REFL = 8'hE0;
   localparam logic [7:0] UI_RESET      = 8'h03;

   // Counter width default
   localparam int COUNTER_BITS_DEF = 16;
   localparam int COUNT_OUT_BITS   = 16;

   // Register map
   localparam int CSR_ADDR_BITS = 3;
   localparam logic CSR_IDX_UI_CONTROL = 1'b0;

   // Result kinds
   typedef enum logic [1:0] {
      KIND_PAYLOAD   = 2'd0,
      KIND_GOOD      = 2'd1,
      KIND_BAD_FCS   = 2'd2,
      KIND_BAD_CLOSE = 2'd3
   } kind_type;

   // Deframer phases
   typedef enum logic [6:0] {
      PH_HUNT    = 7'b0000001,
      PH_FLAGS   = 7'b0000010,
      PH_CTRL    = 7'b0000100,
      PH_LEN     = 7'b0001000,
      PH_PAYLOAD = 7'b0010000,
      PH_FCS     = 7'b0100000,
      PH_CLOSE   = 7'b1000000
   } phase_type;

   // One byte of the reflected CRC-8
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
      end
      return c;
   endfunction

endpackage

### hdl/cmux_basic_frame_deframer_top.sv
// Multiplexer basic-mode frame deframer: one received byte per item.
// A result is registered: it appears on rsp_ in the cycle after the byte that causes it is taken.
// Throughput: one byte per cycle; the frame state and CRC update in a single pass.
// The input stalls only while a result is held and rsp_stall is high.
// Reset (synchronous, active high): hunting, CRC 0xFF, counts zero, UI control 3.
`include "assert_macros.svh"
module cmux_basic_frame_deframer_top #(
   parameter int COUNTER_BITS = cmuxdf_pkg::COUNTER_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // byte input
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [7:0]                           req_rx_byte,
   // result output
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [1:0]                           rsp_item_kind,
   output logic [7:0]                           rsp_payload_byte,
   output logic [5:0]                           rsp_channel,
   output logic [7:0]                           rsp_control_byte,
   output logic [6:0]                           rsp_frame_length,
   output logic                                 rsp_is_last,
   output logic [15:0]                          rsp_good_frames,
   output logic [15:0]                          rsp_dropped_frames,
   // configuration
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [cmuxdf_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  logic [31:0]                          pwdata,
   output logic [31:0]                          prdata,
   output logic                                 pready
);
   import cmuxdf_pkg::*;

   logic [7:0]              ui_control;
   logic                    accept;
   logic [7:0]              b;
   logic                    is_ui;
   logic [7:0]              crc_base;
   logic [7:0]              crc_next;
   logic [6:0]              left_dec;

   phase_type               phase_ff, phase_in;
   logic [7:0]              crc_ff, crc_in;
   logic [5:0]              chan_ff, chan_in;
   logic [7:0]              ctrl_ff, ctrl_in;
   logic [6:0]              len_ff, len_in;
   logic [6:0]              left_ff, left_in;
   logic [COUNTER_BITS-1:0] good_ff, good_in;
   logic [COUNTER_BITS-1:0] drop_ff, drop_in;

   logic                    res_valid;
   kind_type                res_kind;
   logic [7:0]              res_payload;

   logic                    out_valid_ff;
   kind_type                out_kind_ff;
   logic [7:0]              out_payload_ff;
   logic [5:0]              out_chan_ff;
   logic [7:0]              out_ctrl_ff;
   logic [6:0]              out_len_ff;
   logic [COUNTER_BITS-1:0] out_good_ff;
   logic [COUNTER_BITS-1:0] out_drop_ff;

   cmuxdf_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .ui_control (ui_control)
   );

   // Hold the input only while a result waits downstream
   assign req_stall = out_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign b         = req_rx_byte;

   // Shared CRC step: the address byte restarts from the init value
   assign crc_base = (phase_ff == PH_FLAGS) ? CRC_INIT : crc_ff;
   assign crc_next = crc8_byte(crc_base, b);
   assign is_ui    = ((ctrl_ff & PF_CLEAR_MASK) == ui_control);
   assign left_dec = left_ff - 7'd1;

   // Advance the frame state for one byte
   always_comb begin
      phase_in    = phase_ff;
      crc_in      = crc_ff;
      chan_in     = chan_ff;
      ctrl_in     = ctrl_ff;
      len_in      = len_ff;
      left_in     = left_ff;
      good_in     = good_ff;
      drop_in     = drop_ff;
      res_valid   = 1'b0;
      res_kind    = KIND_PAYLOAD;
      res_payload = 8'd0;
      unique case (phase_ff)
         PH_FLAGS: begin
            if (b != FLAG_BYTE) begin
               chan_in  = b[7:2];
               crc_in   = crc_next;
               phase_in = PH_CTRL;
            end
         end
         PH_CTRL: begin
            ctrl_in  = b;
            crc_in   = crc_next;
            phase_in = PH_LEN;
         end
         PH_LEN: begin
            len_in  = b[7:1];
            crc_in  = crc_next;
            left_in = b[7:1];
            if (!b[0]) begin
               phase_in = PH_HUNT;
            end else if (b[7:1] != 7'd0) begin
               phase_in = PH_PAYLOAD;
            end else begin
               phase_in = PH_FCS;
            end
         end
         PH_PAYLOAD: begin
            if (is_ui) begin
               crc_in = crc_next;
            end
            left_in = left_dec;
            if (left_dec == 7'd0) begin
               phase_in = PH_FCS;
            end
            res_valid   = 1'b1;
            res_kind    = KIND_PAYLOAD;
            res_payload = b;
         end
         PH_FCS: begin
            if (crc_next != FCS_GOOD) begin
               drop_in   = drop_ff + COUNTER_BITS'(1);
               phase_in  = (b == FLAG_BYTE) ? PH_FLAGS : PH_HUNT;
               res_valid = 1'b1;
               res_kind  = KIND_BAD_FCS;
            end else begin
               phase_in = PH_CLOSE;
            end
         end
         PH_CLOSE: begin
            phase_in  = PH_HUNT;
            res_valid = 1'b1;
            if (b != FLAG_BYTE) begin
               drop_in  = drop_ff + COUNTER_BITS'(1);
               res_kind = KIND_BAD_CLOSE;
            end else begin
               good_in  = good_ff + COUNTER_BITS'(1);
               res_kind = KIND_GOOD;
            end
         end
         default: begin
            phase_in = (b == FLAG_BYTE) ? PH_FLAGS : PH_HUNT;
         end
      endcase
   end

   // Frame state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         crc_ff   <= CRC_INIT;
         chan_ff  <= '0;
         ctrl_ff  <= '0;
         len_ff   <= '0;
         left_ff  <= '0;
         good_ff  <= '0;
         drop_ff  <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         crc_ff   <= crc_in;
         chan_ff  <= chan_in;
         ctrl_ff  <= ctrl_in;
         len_ff   <= len_in;
         left_ff  <= left_in;
         good_ff  <= good_in;
         drop_ff  <= drop_in;
      end
   end

   // Result register: load on a new result, drop once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (accept && res_valid) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && res_valid) begin
         out_kind_ff    <= res_kind;
         out_payload_ff <= res_payload;
         out_chan_ff    <= chan_in;
         out_ctrl_ff    <= ctrl_in;
         out_len_ff     <= len_in;
         out_good_ff    <= good_in;
         out_drop_ff    <= drop_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_item_kind    = out_kind_ff;
   assign rsp_payload_byte = out_payload_ff;
   assign rsp_channel      = out_chan_ff;
   assign rsp_control_byte = out_ctrl_ff;
   assign rsp_frame_length = out_len_ff;
   assign rsp_is_last      = (out_kind_ff != KIND_PAYLOAD);

   // Show the low count bits, zero-extended when the counters are narrow
   for (genvar i = 0; i < COUNT_OUT_BITS; i++) begin : g_count_out
      if (i < COUNTER_BITS) begin : g_bit
         assign rsp_good_frames[i]    = out_good_ff[i];
         assign rsp_dropped_frames[i] = out_drop_ff[i];
      end else begin : g_zero
         assign rsp_good_frames[i]    = 1'b0;
         assign rsp_dropped_frames[i] = 1'b0;
      end
   end

   // Status items never carry a payload byte
   `ASSERT_PROP(a_status_no_payload, clock, reset,
      !out_valid_ff || out_kind_ff == KIND_PAYLOAD || out_payload_ff == 8'd0)
   // A drop status advances the drop count by one
   `ASSERT_NEXT(a_drop_counts, clock, reset,
      accept && res_valid && (res_kind == KIND_BAD_FCS || res_kind == KIND_BAD_CLOSE),
      drop_ff == $past(drop_ff) + COUNTER_BITS'(1))
   // The good count moves only on a good-frame status
   `ASSERT_NEXT(a_good_only_on_good, clock, reset,
      !(accept && res_valid && res_kind == KIND_GOOD),
      $stable(good_ff))

endmodule

### hdl/cmuxdf_csr.sv
// Configuration register block of the deframer: APB write and readback.
// Depends on cmuxdf_pkg.
module cmuxdf_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [cmuxdf_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  logic [31:0]                          pwdata,
   output logic [31:0]                          prdata,
   output logic                                 pready,
   output logic [7:0]                           ui_control
);
   import cmuxdf_pkg::*;

   logic       wr_en;
   logic [7:0] ui_control_ff;
   logic [7:0] ui_control_in;

   // Write on the access cycle of an addressed write
   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && (paddr[2] == CSR_IDX_UI_CONTROL);

   always_comb begin
      ui_control_in = ui_control_ff;
      if (wr_en) begin
         ui_control_in = pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ui_control_ff <= UI_RESET;
      end else begin
         ui_control_ff <= ui_control_in;
      end
   end

   // Read back the register, zero elsewhere
   always_comb begin
      prdata = '0;
      if (paddr[2] == CSR_IDX_UI_CONTROL) begin
         prdata = {24'd0, ui_control_ff};
      end
   end

   assign ui_control = ui_control_ff;

endmodule

### sim/tb.sv
// Testbench for cmux_basic_frame_deframer_top: directed frames, then random frame streams.
// Keeps its own model of the deframer to predict each result item.
// Depends on cmuxdf_pkg and the deframer RTL.
module tb;
   import cmuxdf_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLDOFF_CYCLES = 200;
   localparam int N_SETTINGS     = 6;
   localparam int PHASE_BYTES    = 230;
   localparam logic [CSR_ADDR_BITS-1:0] UI_CONTROL_ADDR = CSR_ADDR_BITS'(4 * CSR_IDX_UI_CONTROL);
   localparam logic [7:0] PF_BIT = ~PF_CLEAR_MASK;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  pbyte;
      logic [5:0]  chan;
      logic [7:0]  ctl;
      logic [6:0]  len;
      logic        last;
      logic [15:0] good;
      logic [15:0] drop;
   } frame_result_type;

   typedef struct packed {
      logic             typed;
      frame_result_type res;
   } item_tag_type;

   typedef struct packed {
      logic [7:0]       b;
      logic             typed;
      frame_result_type res;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_item_kind;
   logic [7:0]  rsp_payload_byte;
   logic [5:0]  rsp_channel;
   logic [7:0]  rsp_control_byte;
   logic [6:0]  rsp_frame_length;
   logic        rsp_is_last;
   logic [15:0] rsp_good_frames;
   logic [15:0] rsp_dropped_frames;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] paddr = '0;
   logic [31:0] pwdata = 32'h0;
   logic [31:0] prdata;
   logic        pready;

   cmux_basic_frame_deframer_top DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_item_kind(rsp_item_kind), .rsp_payload_byte(rsp_payload_byte),
      .rsp_channel(rsp_channel), .rsp_control_byte(rsp_control_byte),
      .rsp_frame_length(rsp_frame_length), .rsp_is_last(rsp_is_last),
      .rsp_good_frames(rsp_good_frames), .rsp_dropped_frames(rsp_dropped_frames),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Deframer model state, starting from its reset values
   phase_type   df_phase = PH_HUNT;
   logic [7:0]  df_crc = CRC_INIT;
   logic [5:0]  df_chan = '0;
   logic [7:0]  df_ctl = '0;
   logic [6:0]  df_len = '0;
   logic [6:0]  df_left = '0;
   logic [15:0] df_good = '0;
   logic [15:0] df_drop = '0;
   logic [7:0]  ui_value = UI_RESET;

   frame_result_type pending_results[$];
   item_tag_type     item_tags[$];
   dir_row_type      dir_rows[$];
   logic [7:0]       tbl_crc;

   int fails = 0;
   int send_idle_pct = 26;
   int rsp_idle_pct = 26;
   int holdoff_req = 0;
   int holdoff_ack = 0;
   int holdoff_left = 0;
   int quiet_cycles = 0;
   int frame_bytes = 0;
   int kind_seen[4] = '{0, 0, 0, 0};

   // Reflected CRC-8, shifted in one data bit at a time
   function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] d);
      logic [7:0] c;
      logic fb;
      c = crc;
      for (int i = 0; i < 8; i++) begin
         fb = c[0] ^ d[i];
         c = {1'b0, c[7:1]} ^ (fb ? 8'hE0 : 8'h00);
      end
      return c;
   endfunction

   // Find the FCS byte that leaves the good residue
   function automatic logic [7:0] closing_fcs(input logic [7:0] crc);
      logic [7:0] f;
      f = 8'h00;
      for (int i = 0; i < 256; i++) begin
         if (crc_step(crc, 8'(i)) == FCS_GOOD) f = 8'(i);
      end
      return f;
   endfunction

   function automatic frame_result_type frame_status(input kind_type k, input logic [7:0] pb);
      frame_result_type r;
      r.kind = k;
      r.pbyte = pb;
      r.chan = df_chan;
      r.ctl = df_ctl;
      r.len = df_len;
      r.last = (k != KIND_PAYLOAD);
      r.good = df_good;
      r.drop = df_drop;
      return r;
   endfunction

   // Advance the deframer model by one received byte
   task automatic deframe_byte(input logic [7:0] b, output logic hit,
                               output frame_result_type r);
      hit = 1'b0;
      r = '0;
      case (df_phase)
         PH_FLAGS: begin
            if (b != FLAG_BYTE) begin
               df_chan = b[7:2];
               df_crc = crc_step(CRC_INIT, b);
               df_phase = PH_CTRL;
            end
         end
         PH_CTRL: begin
            df_ctl = b;
            df_crc = crc_step(df_crc, b);
            df_phase = PH_LEN;
         end
         PH_LEN: begin
            df_len = b[7:1];
            df_crc = crc_step(df_crc, b);
            if (!b[0]) begin
               df_phase = PH_HUNT;
            end else begin
               df_left = df_len;
               df_phase = (df_len != 0) ? PH_PAYLOAD : PH_FCS;
            end
         end
         PH_PAYLOAD: begin
            if ((df_ctl & PF_CLEAR_MASK) == ui_value) df_crc = crc_step(df_crc, b);
            df_left = df_left - 7'd1;
            if (df_left == 0) df_phase = PH_FCS;
            hit = 1'b1;
            r = frame_status(KIND_PAYLOAD, b);
         end
         PH_FCS: begin
            if (crc_step(df_crc, b) != FCS_GOOD) begin
               df_drop = df_drop + 16'd1;
               df_phase = (b == FLAG_BYTE) ? PH_FLAGS : PH_HUNT;
               hit = 1'b1;
               r = frame_status(KIND_BAD_FCS, 8'h00);
            end else begin
               df_phase = PH_CLOSE;
            end
         end
         PH_CLOSE: begin
            df_phase = PH_HUNT;
            hit = 1'b1;
            if (b != FLAG_BYTE) begin
               df_drop = df_drop + 16'd1;
               r = frame_status(KIND_BAD_CLOSE, 8'h00);
            end else begin
               df_good = df_good + 16'd1;
               r = frame_status(KIND_GOOD, 8'h00);
            end
         end
         default: begin
            df_phase = (b == FLAG_BYTE) ? PH_FLAGS : PH_HUNT;
         end
      endcase
   endtask

   task automatic compare_result(input frame_result_type want, input frame_result_type got);
      if (got.kind != want.kind) begin
         $error("item_kind: expected %0d, got %0d", want.kind, got.kind);
         fails++;
      end
      if (got.pbyte != want.pbyte) begin
         $error("payload_byte: expected %0h, got %0h", want.pbyte, got.pbyte);
         fails++;
      end
      if (got.chan != want.chan) begin
         $error("channel: expected %0d, got %0d", want.chan, got.chan);
         fails++;
      end
      if (got.ctl != want.ctl) begin
         $error("control_byte: expected %0h, got %0h", want.ctl, got.ctl);
         fails++;
      end
      if (got.len != want.len) begin
         $error("frame_length: expected %0d, got %0d", want.len, got.len);
         fails++;
      end
      if (got.last != want.last) begin
         $error("is_last: expected %0d, got %0d", want.last, got.last);
         fails++;
      end
      if (got.good != want.good) begin
         $error("good_frames: expected %0d, got %0d", want.good, got.good);
         fails++;
      end
      if (got.drop != want.drop) begin
         $error("dropped_frames: expected %0d, got %0d", want.drop, got.drop);
         fails++;
      end
   endtask

   // Check each result item, then predict from each accepted byte
   always @(posedge clock) begin : watch_channels
      frame_result_type got;
      frame_result_type pred;
      item_tag_type tag;
      logic hit;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got.kind = kind_type'(rsp_item_kind);
            got.pbyte = rsp_payload_byte;
            got.chan = rsp_channel;
            got.ctl = rsp_control_byte;
            got.len = rsp_frame_length;
            got.last = rsp_is_last;
            got.good = rsp_good_frames;
            got.drop = rsp_dropped_frames;
            kind_seen[rsp_item_kind]++;
            if (pending_results.size() == 0) begin
               $error("result item arrived with nothing expected");
               fails++;
            end else begin
               compare_result(pending_results.pop_front(), got);
            end
         end
         if (req_valid && !req_stall) begin
            tag = item_tags.pop_front();
            deframe_byte(req_rx_byte, hit, pred);
            if (tag.typed) pending_results.push_back(tag.res);
            else if (hit) pending_results.push_back(pred);
         end
      end
   end

   // Receiver: random stalls, or a counted hold-off when one is requested
   always @(posedge clock) begin
      if (holdoff_left != 0) begin
         rsp_stall <= 1'b1;
         holdoff_left <= holdoff_left - 1;
      end else if (holdoff_req != holdoff_ack) begin
         holdoff_ack <= holdoff_req;
         holdoff_left <= HOLDOFF_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
   end

   // End the run when neither channel moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("cmux_basic_frame_deframer_top test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offer one byte, with random idle cycles first; return once it is taken
   task automatic send_byte(input logic [7:0] b, input logic typed = 1'b0,
                            input frame_result_type res = '0);
      item_tag_type tag;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      tag.typed = typed;
      tag.res = res;
      item_tags.push_back(tag);
      req_valid <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Drop valid and hold until every expected result item has come
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   // Write the UI control register, then read it back
   task automatic csr_write_ui(input logic [7:0] v);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= UI_CONTROL_ADDR;
      pwdata <= {24'h0, v};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      ui_value = v;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata[7:0] != v) begin
         $error("ui_control_value readback: expected %0h, got %0h", v, prdata[7:0]);
         fails++;
      end
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic add_row(input logic [7:0] b, input logic covered);
      dir_row_type row;
      if (covered) tbl_crc = crc_step(tbl_crc, b);
      row.b = b;
      row.typed = 1'b0;
      row.res = '0;
      dir_rows.push_back(row);
   endtask

   task automatic add_typed(input logic [7:0] b, input logic covered, input kind_type k,
                            input logic [7:0] pb, input logic [5:0] ch, input logic [7:0] ctl,
                            input logic [6:0] len, input logic [15:0] good,
                            input logic [15:0] drop);
      dir_row_type row;
      if (covered) tbl_crc = crc_step(tbl_crc, b);
      row.b = b;
      row.typed = 1'b1;
      row.res.kind = k;
      row.res.pbyte = pb;
      row.res.chan = ch;
      row.res.ctl = ctl;
      row.res.len = len;
      row.res.last = (k != KIND_PAYLOAD);
      row.res.good = good;
      row.res.drop = drop;
      dir_rows.push_back(row);
   endtask

   // Send one frame with random content; force_len < 0 picks a random length
   task automatic send_frame(input int force_len);
      logic [7:0] crc;
      logic [7:0] addr;
      logic [7:0] ctl;
      logic [7:0] lenb;
      logic [7:0] b;
      logic [6:0] len;
      logic ui_frame;
      int n;
      // hunting noise, not counted
      n = ($urandom_range(9) == 0) ? $urandom_range(1, 3) : 0;
      repeat (n) send_byte(8'($urandom_range(255)));
      n = ($urandom_range(4) == 0) ? $urandom_range(2, 3) : 1;
      repeat (n) begin
         send_byte(FLAG_BYTE);
         frame_bytes++;
      end
      addr = 8'($urandom_range(255));
      if ($urandom_range(1) && !ui_value[4]) begin
         ctl = ui_value | ($urandom_range(1) ? PF_BIT : 8'h00);
      end else begin
         ctl = 8'($urandom_range(255));
      end
      if (force_len >= 0) len = 7'(force_len);
      else if ($urandom_range(29) == 0) len = 7'd127;
      else if ($urandom_range(4) == 0) len = 7'($urandom_range(7, 20));
      else len = 7'($urandom_range(0, 6));
      lenb = {len, ($urandom_range(19) != 0)};
      crc = crc_step(crc_step(crc_step(CRC_INIT, addr), ctl), lenb);
      send_byte(addr);
      send_byte(ctl);
      send_byte(lenb);
      frame_bytes += 3;
      if (!lenb[0]) return;
      ui_frame = ((ctl & PF_CLEAR_MASK) == ui_value);
      for (int i = 0; i < len; i++) begin
         b = ($urandom_range(15) == 0) ? FLAG_BYTE : 8'($urandom_range(255));
         if (ui_frame) crc = crc_step(crc, b);
         send_byte(b);
         frame_bytes++;
      end
      if ($urandom_range(99) < 85) b = closing_fcs(crc);
      else if ($urandom_range(2) == 0) b = FLAG_BYTE;
      else b = 8'($urandom_range(255));
      send_byte(b);
      b = ($urandom_range(99) < 88) ? FLAG_BYTE : 8'($urandom_range(255));
      send_byte(b);
      frame_bytes += 2;
   endtask

   initial begin : run_test
      logic [7:0] settings[N_SETTINGS];
      int target;

      // Directed table: noise, repeated flags, extremes, EA clear, every status kind
      tbl_crc = CRC_INIT;
      add_row(8'h00, 1'b0);
      add_row(FLAG_BYTE, 1'b0);
      add_row(FLAG_BYTE, 1'b0);
      tbl_crc = CRC_INIT;
      add_row(8'hFC, 1'b1);
      add_row(8'hFF, 1'b1);
      add_row(8'h01, 1'b1);
      add_row(closing_fcs(tbl_crc), 1'b0);
      add_typed(8'h00, 1'b0, KIND_BAD_CLOSE, 8'h00, 6'd63, 8'hFF, 7'd0, 16'd0, 16'd1);
      add_row(FLAG_BYTE, 1'b0);
      tbl_crc = CRC_INIT;
      add_row(8'h03, 1'b1);
      add_row(8'h03, 1'b1);
      add_row(8'h03, 1'b1);
      add_typed(8'h00, 1'b1, KIND_PAYLOAD, 8'h00, 6'd0, 8'h03, 7'd1, 16'd0, 16'd1);
      add_row(closing_fcs(tbl_crc), 1'b0);
      add_typed(FLAG_BYTE, 1'b0, KIND_GOOD, 8'h00, 6'd0, 8'h03, 7'd1, 16'd1, 16'd1);
      add_row(FLAG_BYTE, 1'b0);
      add_row(8'h07, 1'b0);
      add_row(8'h13, 1'b0);
      add_row(8'h00, 1'b0);
      add_row(FLAG_BYTE, 1'b0);
      tbl_crc = CRC_INIT;
      add_row(8'h0B, 1'b1);
      add_row(8'hEF, 1'b1);
      add_row(8'h05, 1'b1);
      add_typed(8'hFF, 1'b0, KIND_PAYLOAD, 8'hFF, 6'd2, 8'hEF, 7'd2, 16'd1, 16'd1);
      add_row(FLAG_BYTE, 1'b0);
      // bad FCS that is a flag: opens the next frame
      if (closing_fcs(tbl_crc) != FLAG_BYTE) begin
         add_typed(FLAG_BYTE, 1'b0, KIND_BAD_FCS, 8'h00, 6'd2, 8'hEF, 7'd2, 16'd1, 16'd2);
      end else begin
         add_row(FLAG_BYTE, 1'b0);
      end

      settings[0] = 8'h00;
      settings[1] = 8'hFF;
      settings[2] = 8'hEF;
      settings[3] = 8'($urandom_range(255));
      settings[4] = UI_RESET;
      settings[5] = 8'($urandom_range(255)) & PF_CLEAR_MASK;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) send_byte(dir_rows[i].b, dir_rows[i].typed, dir_rows[i].res);

      // Random frame streams, one control setting per phase
      for (int ph = 0; ph < N_SETTINGS; ph++) begin
         wait_drained();
         repeat (4) @(posedge clock);
         csr_write_ui(settings[ph]);
         send_idle_pct = (ph == 1) ? 0 : 26;
         rsp_idle_pct = (ph == 1) ? 0 : 26;
         if (ph == 3) begin
            // stall the receiver while a long payload keeps coming
            holdoff_req++;
            send_frame(127);
         end
         target = frame_bytes + PHASE_BYTES;
         while (frame_bytes < target) begin
            send_frame(-1);
            if (ph == 4 && frame_bytes >= target - PHASE_BYTES / 2 && holdoff_req == 1) begin
               // pause the sender until all results are in
               wait_drained();
               holdoff_req = 1;
               send_idle_pct = 27;
            end
         end
      end

      wait_drained();
      repeat (8) @(posedge clock);
      $display("Sent %0d frame bytes under %0d UI control settings plus the reset one.",
               frame_bytes, N_SETTINGS);
      $display("Checked %0d payload, %0d good, %0d bad-FCS and %0d bad-close items.",
               kind_seen[KIND_PAYLOAD], kind_seen[KIND_GOOD], kind_seen[KIND_BAD_FCS],
               kind_seen[KIND_BAD_CLOSE]);
      if (fails == 0) begin
         $display("cmux_basic_frame_deframer_top test passed");
      end else begin
         $display("cmux_basic_frame_deframer_top test failed");
      end
      $finish;
   end
endmodule
